FILE: rtl/core/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared request codes, status codes and controller/datapath interface types
// for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // request codes
    localparam logic [2:0] REQ_ADD_FRONT = 3'd0;
    localparam logic [2:0] REQ_DEL_FRONT = 3'd1;
    localparam logic [2:0] REQ_ADD_BACK  = 3'd2;
    localparam logic [2:0] REQ_DEL_BACK  = 3'd3;
    localparam logic [2:0] REQ_LIST      = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // datapath operation: ring pointer update and store access
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD_FRONT,
        OP_ADD_BACK,
        OP_DEL_FRONT,
        OP_DEL_BACK,
        OP_LIST_START,
        OP_LIST_NEXT
    } t_op;

    // controller to datapath
    typedef struct packed {
        t_op        op;
        logic       out_load;   // capture result word
        logic       out_ram;    // result value from store, else zero
        logic [1:0] out_status;
        logic       out_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;        // current list offset is the back entry
    } t_dp_stat;

endpackage

FILE: rtl/core/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bdq_dp.sv
// ----------------------------------------------------------------------------
// bdq_dp
// Deque datapath: ring store, front index, entry count, list offset and the
// result word register.
// ----------------------------------------------------------------------------
module bdq_dp
    import bdq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic signed [31:0] i_value_in,
    output t_dp_stat           o_stat,
    output logic signed [31:0] o_value_out,
    output logic [1:0]         o_status,
    output logic               o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;

    logic               r_value_last;
    logic signed [31:0] r_value_out;
    logic [1:0]         r_status;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   rdata;
    logic [AW-1:0] front_dec;
    logic [CW-1:0] idx_inc;

    // ring slot at an offset from the front; sum stays below twice the depth
    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] front,
                                              input logic [CW-1:0] offset);
        logic [SW-1:0] sum;
        sum = SW'(front) + SW'(offset);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign idx_inc   = r_idx + CW'(1);

    // pointer update and store access per operation
    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_idx   = r_idx;
        we      = 1'b0;
        re      = 1'b0;
        waddr   = r_front;
        raddr   = r_front;
        case (i_cmd.op)
            OP_ADD_FRONT: begin
                we      = 1'b1;
                waddr   = front_dec;
                n_front = front_dec;
                n_count = r_count + CW'(1);
            end
            OP_ADD_BACK: begin
                we      = 1'b1;
                waddr   = slot_at(r_front, r_count);
                n_count = r_count + CW'(1);
            end
            OP_DEL_FRONT: begin
                re      = 1'b1;
                raddr   = r_front;
                n_front = slot_at(r_front, CW'(1));
                n_count = r_count - CW'(1);
            end
            OP_DEL_BACK: begin
                re      = 1'b1;
                raddr   = slot_at(r_front, r_count - CW'(1));
                n_count = r_count - CW'(1);
            end
            OP_LIST_START: begin
                re    = 1'b1;
                raddr = r_front;
                n_idx = '0;
            end
            OP_LIST_NEXT: begin
                re    = 1'b1;
                raddr = slot_at(r_front, idx_inc);
                n_idx = idx_inc;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    bdq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_value_in),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // result word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_value_out  <= i_cmd.out_ram ? signed'(rdata) : 32'sd0;
            r_status     <= i_cmd.out_status;
            r_value_last <= i_cmd.out_last;
        end
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.list_last = (idx_inc == r_count);

    assign o_value_out = r_value_out;
    assign o_status    = r_status;
    assign o_last      = r_value_last;

endmodule

FILE: rtl/core/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Deque controller: request decode, store read wait and result handshake.
// ----------------------------------------------------------------------------
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_req_type,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_is_list, n_is_list;

    always_comb begin
        n_state   = r_state;
        n_is_list = r_is_list;
        o_cmd     = '{op: OP_NONE, out_load: 1'b0, out_ram: 1'b0,
                      out_status: ST_OK, out_last: 1'b1};
        case (r_state)
            // take a request word and decode it
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_req_type) inside
                        REQ_ADD_FRONT, REQ_ADD_BACK: begin
                            o_cmd.out_load = 1'b1;
                            n_state        = S_OUT;
                            if (i_stat.full) begin
                                o_cmd.out_status = ST_FULL;
                            end else begin
                                o_cmd.op = (i_req_type == REQ_ADD_FRONT) ?
                                           OP_ADD_FRONT : OP_ADD_BACK;
                            end
                        end
                        REQ_DEL_FRONT, REQ_DEL_BACK, REQ_LIST: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                                n_state          = S_OUT;
                            end else begin
                                n_state   = S_READ;
                                n_is_list = (i_req_type == REQ_LIST);
                                case (i_req_type)
                                    REQ_DEL_FRONT: o_cmd.op = OP_DEL_FRONT;
                                    REQ_DEL_BACK:  o_cmd.op = OP_DEL_BACK;
                                    default:       o_cmd.op = OP_LIST_START;
                                endcase
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // store data is ready: capture it as the result word
            S_READ: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_ram  = 1'b1;
                o_cmd.out_last = r_is_list ? i_stat.list_last : 1'b1;
                n_state        = S_OUT;
            end
            // hold the result until taken; lists step to the next entry
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_is_list && !i_stat.list_last) begin
                        o_cmd.op = OP_LIST_NEXT;
                        n_state  = S_READ;
                    end else begin
                        n_state   = S_IDLE;
                        n_is_list = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_is_list <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_list <= n_is_list;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

FILE: rtl/core/bounded_deque.sv
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of up to DEPTH signed 32-bit words in a ring store.
//
// Input channel (i_in_valid / o_in_stall): a request word carries a request
// type (add front, remove front, add back, remove back, list all) and a value
// used by adds. Unused request codes are taken and dropped without a result.
// Output channel (o_out_valid / i_out_stall): each result word carries a
// value, a status (ok, empty, full) and a last flag on the final word of a
// request.
// One request at a time. An add gives its result the cycle after it is taken
// and the next request is taken the cycle after the result leaves. A remove
// first passes through a state that waits on the registered store read port.
// A list makes one store read and gives one result word per entry. Refused
// and empty requests answer like an add.
// While the receiver stalls, the result word holds and no request is taken.
// Reset (synchronous) empties the deque; store contents need no clearing.
// ----------------------------------------------------------------------------
module bounded_deque
    import bdq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_value_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_value_out,
    output logic [1:0]         o_status,
    output logic               o_last
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value_in  (i_value_in),
        .o_stat      (stat),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    // no request is taken while a result word is pending
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !o_out_valid)
        else $error("request taken while result pending");

    // an add always answers in the next cycle
    a_add_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall &&
         (i_req_type == REQ_ADD_FRONT || i_req_type == REQ_ADD_BACK))
        |=> (o_out_valid && o_last && o_value_out == 32'sd0))
        else $error("add result missing or malformed");

    // refused and empty results are single zero words
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL || o_status == ST_EMPTY))
        |-> (o_last && o_value_out == 32'sd0))
        else $error("full or empty result not a single zero word");
`endif

endmodule

FILE: tb/sv/bounded_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_tb
// Self-checking bench for the bounded deque. A clocked driver sends request
// words from a pending queue; a clocked monitor checks every result word
// against a deque predictor kept in the bench. Both channels idle at random.
// ----------------------------------------------------------------------------
module bounded_deque_tb;
    import bdq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int IDLE_PCT    = 21;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 10;

    // request codes the block drops without a result
    localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] REQ_RESERVED_MID   = 3'd6;
    localparam logic [2:0] REQ_RESERVED_LAST  = 3'd7;

    typedef struct {
        logic [2:0]         req;
        logic signed [31:0] value;
    } t_req_word;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic               last;
    } t_result_word;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_req_type  = REQ_LIST;
    logic signed [31:0] i_value_in  = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_value_out;
    logic [1:0]         o_status;
    logic               o_last;

    t_req_word    pending_reqs[$];
    t_result_word expected_words[$];

    // predictor state
    logic signed [31:0] model_ring[DEPTH];
    int                 model_front = 0;
    int                 model_count = 0;

    // generator bookkeeping, used only to shape the stimulus
    int gen_count      = 0;
    int gen_full_hits  = 0;
    int gen_empty_hits = 0;

    int           error_count  = 0;
    int           cycle_count  = 0;
    int           accepted_cnt = 0;
    int           result_cnt   = 0;
    t_req_word    next_req;
    t_result_word want;

    bounded_deque #(.DEPTH(DEPTH)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_value_in  (i_value_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Deque predictor: apply one request, queue the result words it causes
    // ------------------------------------------------------------------------
    function automatic int ring_slot(input int offset);
        return (model_front + offset) % DEPTH;
    endfunction

    task automatic push_result(input logic signed [31:0] value, input logic [1:0] status,
                               input logic last);
        t_result_word w;
        w.value  = value;
        w.status = status;
        w.last   = last;
        expected_words.push_back(w);
    endtask

    task automatic apply_request(input logic [2:0] req, input logic signed [31:0] value);
        int s;
        case (req)
            REQ_ADD_FRONT, REQ_ADD_BACK: begin
                if (model_count >= DEPTH) begin
                    push_result('0, ST_FULL, 1'b1);
                end else begin
                    if (req == REQ_ADD_FRONT) begin
                        model_front = (model_front == 0) ? DEPTH - 1 : model_front - 1;
                        model_ring[model_front] = value;
                    end else begin
                        model_ring[ring_slot(model_count)] = value;
                    end
                    model_count++;
                    push_result('0, ST_OK, 1'b1);
                end
            end
            REQ_DEL_FRONT: begin
                if (model_count == 0) begin
                    push_result('0, ST_EMPTY, 1'b1);
                end else begin
                    s = model_front;
                    model_front = ring_slot(1);
                    model_count--;
                    push_result(model_ring[s], ST_OK, 1'b1);
                end
            end
            REQ_DEL_BACK: begin
                if (model_count == 0) begin
                    push_result('0, ST_EMPTY, 1'b1);
                end else begin
                    model_count--;
                    push_result(model_ring[ring_slot(model_count)], ST_OK, 1'b1);
                end
            end
            REQ_LIST: begin
                if (model_count == 0) begin
                    push_result('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < model_count; i++)
                        push_result(model_ring[ring_slot(i)], ST_OK, i + 1 == model_count);
                end
            end
            default: ; // reserved codes: no result, no state change
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    task automatic queue_req(input logic [2:0] req, input logic signed [31:0] value);
        t_req_word w;
        w.req   = req;
        w.value = value;
        pending_reqs.push_back(w);
        case (req)
            REQ_ADD_FRONT, REQ_ADD_BACK: begin
                if (gen_count >= DEPTH) gen_full_hits++;
                else gen_count++;
            end
            REQ_DEL_FRONT, REQ_DEL_BACK: begin
                if (gen_count == 0) gen_empty_hits++;
                else gen_count--;
            end
            default: ;
        endcase
    endtask

    // one random request word; add_pct and del_pct set the mix, lists fill the rest
    task automatic queue_random_req(input int add_pct, input int del_pct);
        int r;
        logic [2:0] noise;
        // occasional reserved code on top of the counted words
        if ($urandom_range(99) < 4) begin
            noise = REQ_RESERVED_FIRST + 3'($urandom_range(2));
            queue_req(noise, $urandom);
        end
        r = $urandom_range(99);
        if (r < add_pct)
            queue_req($urandom_range(1) ? REQ_ADD_BACK : REQ_ADD_FRONT, $urandom);
        else if (r < add_pct + del_pct)
            queue_req($urandom_range(1) ? REQ_DEL_BACK : REQ_DEL_FRONT, $urandom);
        else
            queue_req(REQ_LIST, $urandom);
    endtask

    // grow until the deque has refused a couple of adds
    task automatic queue_fill_phase();
        int hits;
        hits = gen_full_hits;
        while (gen_full_hits < hits + 2)
            queue_random_req(88, 7);
    endtask

    // shrink until a couple of removes found it empty
    task automatic queue_drain_phase();
        int hits;
        hits = gen_empty_hits;
        while (gen_empty_hits < hits + 2)
            queue_random_req(7, 88);
    endtask

    initial begin
        // directed: empty cases, extreme values, reserved codes, both ends
        queue_req(REQ_LIST,      32'sd0);
        queue_req(REQ_DEL_FRONT, 32'sd0);
        queue_req(REQ_DEL_BACK,  32'sd0);
        queue_req(REQ_ADD_FRONT, 32'sh8000_0000);
        queue_req(REQ_ADD_BACK,  32'sh7FFF_FFFF);
        queue_req(REQ_ADD_FRONT, 32'sd0);
        queue_req(REQ_ADD_BACK,  -32'sd1);
        queue_req(REQ_ADD_FRONT, 32'sh5555_5555);
        queue_req(REQ_ADD_BACK,  32'shAAAA_AAAA);
        queue_req(REQ_LIST,      32'sh1234_5678);
        queue_req(REQ_RESERVED_FIRST, 32'sh7FFF_FFFF);
        queue_req(REQ_RESERVED_MID,   32'sh8000_0000);
        queue_req(REQ_RESERVED_LAST,  -32'sd1);
        queue_req(REQ_DEL_FRONT, -32'sd1);
        queue_req(REQ_DEL_BACK,  -32'sd1);
        queue_req(REQ_LIST,      32'sd0);
        queue_req(REQ_DEL_FRONT, 32'sd0);
        queue_req(REQ_DEL_BACK,  32'sd0);
        queue_req(REQ_DEL_FRONT, 32'sd0);
        queue_req(REQ_DEL_BACK,  32'sd0);
        queue_req(REQ_DEL_BACK,  32'sd0);
        queue_req(REQ_LIST,      32'sd0);

        // random: fill to full, drain to empty, then a mix
        queue_fill_phase();
        queue_drain_phase();
        repeat (100) queue_random_req(40, 45);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("** bounded_deque: PASSED **");
        else
            $display("** bounded_deque: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: present request words, predict each one as it is taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                apply_request(i_req_type, i_value_in);
                accepted_cnt++;
            end
            // load a new word only once the current one is gone
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() != 0 &&
                    ((accepted_cnt >= 120 && accepted_cnt < 180) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    next_req = pending_reqs.pop_front();
                    i_req_type <= next_req.req;
                    i_value_in <= next_req.value;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random stall, compare each taken result word with the oldest one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                result_cnt++;
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: value_out %0d status %0d last %0d",
                           o_value_out, o_status, o_last);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_value_out !== want.value) begin
                        $error("value_out: expected %0d, actual %0d", want.value, o_value_out);
                        error_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, o_last);
                        error_count++;
                    end
                end
            end
            i_out_stall <= !(result_cnt >= 300 && result_cnt < 700) &&
                           ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** bounded_deque: FAILED **");
            $finish;
        end
    end

endmodule
